// ===== design/stk_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// STK500 page programmer package
// Shared types and protocol constants.
// ----------------------------------------------------------------------------
package stk_pkg;

	localparam logic [1:0] OP_START = 2'd0;
	localparam logic [1:0] OP_PAGE  = 2'd1;
	localparam logic [1:0] OP_RX    = 2'd2;
	localparam logic [1:0] OP_TICK  = 2'd3;

	localparam logic [1:0] ST_BUSY  = 2'd0;
	localparam logic [1:0] ST_READY = 2'd1;
	localparam logic [1:0] ST_FAIL  = 2'd2;
	localparam logic [1:0] ST_DONE  = 2'd3;

	localparam logic [7:0] RESP_IN_SYNC = 8'h14;
	localparam logic [7:0] RESP_OK      = 8'h10;
	localparam logic [7:0] CMD_SYNC     = 8'h30;
	localparam logic [7:0] CRC_EOP      = 8'h20;
	localparam logic [7:0] CMD_ENTER    = 8'h50;
	localparam logic [7:0] CMD_ADDR     = 8'h55;
	localparam logic [7:0] CMD_PROG     = 8'h64;
	localparam logic [7:0] MEM_FLASH    = 8'h46;
	localparam logic [7:0] CMD_LEAVE    = 8'h51;
	localparam logic [15:0] TIMEOUT_RST = 16'd1000;

	// Transmit jobs handed from the front part to the back part.
	localparam logic [2:0] JOB_NONE  = 3'd0;
	localparam logic [2:0] JOB_SYNC  = 3'd1;
	localparam logic [2:0] JOB_ENTER = 3'd2;
	localparam logic [2:0] JOB_ADDR  = 3'd3;
	localparam logic [2:0] JOB_PROG  = 3'd4;
	localparam logic [2:0] JOB_LEAVE = 3'd5;

	typedef struct packed {
		logic [2:0]  kind;
		logic [1:0]  status;
		logic [15:0] addr;
		logic [5:0]  fill;
	} job_t;

endpackage
`default_nettype wire

// ===== design/stk500_page_programmer.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// STK500 page programmer
// Host side of the STK500v1 bootloader protocol with page buffering.
// ----------------------------------------------------------------------------
// The front part takes one item per cycle while the two-entry job queue has
// room and updates the protocol state at once. The back part turns each job
// into result items: it picks up the job, then emits its results in order,
// and inserts a fetch step before each page data byte and before the closing
// byte for the page buffer's registered read. A stalled result holds the back
// part. An item that sends nothing still yields one result item, marked last.
module stk500_page_programmer #(
	parameter int PAGE_BYTES = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  operation,
	input  wire logic [7:0]  value,
	input  wire logic        page_end,
	input  wire logic [15:0] total_size,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic             tx_valid,
	output logic [7:0]       tx_byte,
	output logic [1:0]       status,
	output logic             last,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [15:0] cfg_data
);
	localparam int AW = $clog2(PAGE_BYTES);

	logic [15:0]   timeout_q;
	logic          push, full, nempty, pop, we;
	stk_pkg::job_t push_job, head;
	logic [AW-1:0] waddr, raddr;
	logic [7:0]    rdata;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= stk_pkg::TIMEOUT_RST;
		end else if (cfg_valid) begin
			timeout_q <= cfg_data;
		end
	end

	stk_front #(.PAGE_BYTES(PAGE_BYTES)) u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.operation(operation), .value(value), .page_end(page_end),
		.total_size(total_size), .timeout_ticks(timeout_q),
		.job_valid(push), .job(push_job), .job_full(full),
		.ram_we(we), .ram_waddr(waddr)
	);

	stk_ram #(.WIDTH(8), .DEPTH(PAGE_BYTES)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(value),
		.raddr(raddr), .rdata(rdata)
	);

	stk_queue u_queue (
		.clk(clk), .arst_n(arst_n), .push(push), .push_job(push_job),
		.full(full), .not_empty(nempty), .head(head), .pop(pop)
	);

	stk_back #(.PAGE_BYTES(PAGE_BYTES)) u_back (
		.clk(clk), .arst_n(arst_n), .job_valid(nempty), .job(head),
		.job_pop(pop), .ram_raddr(raddr), .ram_rdata(rdata),
		.out_valid(out_valid), .out_stall(out_stall), .tx_valid(tx_valid),
		.tx_byte(tx_byte), .status(status), .last(last)
	);
endmodule
`default_nettype wire

// ===== design/stk_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module stk_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

// ===== design/stk_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// STK500 front part
// Accepts items, runs the protocol state and writes page bytes.
// ----------------------------------------------------------------------------
module stk_front #(
	parameter int PAGE_BYTES = 32
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [1:0]                    operation,
	input  wire logic [7:0]                    value,
	input  wire logic                          page_end,
	input  wire logic [15:0]                   total_size,
	input  wire logic [15:0]                   timeout_ticks,
	output logic                               job_valid,
	output stk_pkg::job_t                      job,
	input  wire logic                          job_full,
	output logic                               ram_we,
	output logic [$clog2(PAGE_BYTES)-1:0]      ram_waddr
);
	localparam int AW = $clog2(PAGE_BYTES);
	localparam logic [5:0] PAGE_MAX = 6'(PAGE_BYTES);

	localparam logic [3:0] PH_IDLE       = 4'd0;
	localparam logic [3:0] PH_WAIT_SYNC  = 4'd1;
	localparam logic [3:0] PH_WAIT_PROG  = 4'd2;
	localparam logic [3:0] PH_READY      = 4'd3;
	localparam logic [3:0] PH_WAIT_ADDR  = 4'd4;
	localparam logic [3:0] PH_WAIT_PAGE  = 4'd5;
	localparam logic [3:0] PH_WAIT_LEAVE = 4'd6;
	localparam logic [3:0] PH_FAILED     = 4'd7;
	localparam logic [3:0] PH_DONE       = 4'd8;

	logic [3:0]  phase_q, phase_d;
	logic [15:0] addr_q, addr_d, rem_q, rem_d, ticks_q, ticks_d;
	logic [5:0]  fill_q, fill_d, fill_new;
	logic        rcnt_q, rcnt_d, fok_q, fok_d;
	logic        waiting, done_ev, ok;
	logic [2:0]  kind;
	logic        take;

	assign in_stall = job_full;
	assign take = in_valid && !job_full;
	assign waiting = (phase_q == PH_WAIT_SYNC) || (phase_q == PH_WAIT_PROG) ||
		(phase_q == PH_WAIT_ADDR) || (phase_q == PH_WAIT_PAGE) ||
		(phase_q == PH_WAIT_LEAVE);
	assign fill_new = (fill_q < PAGE_MAX) ? fill_q + 6'd1 : fill_q;
	assign ram_we = take && (operation == stk_pkg::OP_PAGE) && (phase_q == PH_READY) &&
		(fill_q < PAGE_MAX);
	assign ram_waddr = fill_q[AW-1:0];

	always_comb begin
		phase_d = phase_q;
		addr_d = addr_q;
		rem_d = rem_q;
		ticks_d = ticks_q;
		fill_d = fill_q;
		rcnt_d = rcnt_q;
		fok_d = fok_q;
		kind = stk_pkg::JOB_NONE;
		done_ev = 1'b0;
		ok = 1'b0;
		unique case (operation)
			stk_pkg::OP_START: begin
				rem_d = total_size;
				addr_d = '0;
				fill_d = '0;
				rcnt_d = 1'b0;
				fok_d = 1'b0;
				ticks_d = '0;
				kind = stk_pkg::JOB_SYNC;
				phase_d = PH_WAIT_SYNC;
			end
			stk_pkg::OP_PAGE: begin
				if (phase_q == PH_READY) begin
					fill_d = fill_new;
					if (page_end) begin
						kind = stk_pkg::JOB_ADDR;
						rem_d = (rem_q > {10'd0, fill_new}) ? rem_q - {10'd0, fill_new} : '0;
						rcnt_d = 1'b0;
						fok_d = 1'b0;
						ticks_d = '0;
						phase_d = PH_WAIT_ADDR;
					end
				end
			end
			stk_pkg::OP_RX: begin
				if (waiting) begin
					if (!rcnt_q) begin
						fok_d = (value == stk_pkg::RESP_IN_SYNC);
						rcnt_d = 1'b1;
					end else begin
						done_ev = 1'b1;
						ok = fok_q && (value == stk_pkg::RESP_OK);
					end
				end
			end
			default: begin
				if (waiting) begin
					if (ticks_q >= timeout_ticks) begin
						done_ev = 1'b1;
					end else begin
						ticks_d = ticks_q + 16'd1;
					end
				end
			end
		endcase
		if (done_ev) begin
			rcnt_d = 1'b0;
			fok_d = 1'b0;
			ticks_d = '0;
			unique case (phase_q)
				PH_WAIT_SYNC: begin
					kind = stk_pkg::JOB_ENTER;
					phase_d = PH_WAIT_PROG;
				end
				PH_WAIT_PROG: phase_d = ok ? PH_READY : PH_FAILED;
				PH_WAIT_ADDR: begin
					if (ok) begin
						kind = stk_pkg::JOB_PROG;
						phase_d = PH_WAIT_PAGE;
					end else begin
						phase_d = PH_FAILED;
					end
				end
				PH_WAIT_PAGE: begin
					if (!ok) begin
						phase_d = PH_FAILED;
					end else if (rem_q != 16'd0) begin
						addr_d = addr_q + {11'd0, fill_q[5:1]};
						fill_d = '0;
						phase_d = PH_READY;
					end else begin
						fill_d = '0;
						kind = stk_pkg::JOB_LEAVE;
						phase_d = PH_WAIT_LEAVE;
					end
				end
				default: phase_d = PH_DONE;
			endcase
		end
	end

	always_comb begin
		job.kind = kind;
		job.addr = addr_q;
		job.fill = fill_d;
		if (operation == stk_pkg::OP_PAGE && kind == stk_pkg::JOB_ADDR) begin
			job.fill = fill_new;
		end
		if (kind == stk_pkg::JOB_PROG) begin
			job.fill = fill_q;
		end
		unique case (phase_d)
			PH_READY:  job.status = stk_pkg::ST_READY;
			PH_FAILED: job.status = stk_pkg::ST_FAIL;
			PH_DONE:   job.status = stk_pkg::ST_DONE;
			default:   job.status = stk_pkg::ST_BUSY;
		endcase
	end
	assign job_valid = take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			addr_q <= '0;
			rem_q <= '0;
			ticks_q <= '0;
			fill_q <= '0;
			rcnt_q <= 1'b0;
			fok_q <= 1'b0;
		end else if (take) begin
			phase_q <= phase_d;
			addr_q <= addr_d;
			rem_q <= rem_d;
			ticks_q <= ticks_d;
			fill_q <= fill_d;
			rcnt_q <= rcnt_d;
			fok_q <= fok_d;
		end
	end
endmodule
`default_nettype wire

// ===== design/stk_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// STK500 job queue
// Two-entry queue of transmit jobs between the front and back parts.
// ----------------------------------------------------------------------------
module stk_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire stk_pkg::job_t push_job,
	output logic               full,
	output logic               not_empty,
	output stk_pkg::job_t      head,
	input  wire logic          pop
);
	stk_pkg::job_t slot_q [2];
	logic          wp_q, rp_q;
	logic [1:0]    cnt_q;

	assign full = (cnt_q == 2'd2);
	assign not_empty = (cnt_q != 2'd0);
	assign head = slot_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wp_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= ~wp_q;
			end
			if (pop) begin
				rp_q <= ~rp_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end
endmodule
`default_nettype wire

// ===== design/stk_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// STK500 back part
// Expands one job at a time into its transmit bytes as result items.
// ----------------------------------------------------------------------------
module stk_back #(
	parameter int PAGE_BYTES = 32
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     job_valid,
	input  wire stk_pkg::job_t            job,
	output logic                          job_pop,
	output logic [$clog2(PAGE_BYTES)-1:0] ram_raddr,
	input  wire logic [7:0]               ram_rdata,
	output logic                          out_valid,
	input  wire logic                     out_stall,
	output logic                          tx_valid,
	output logic [7:0]                    tx_byte,
	output logic [1:0]                    status,
	output logic                          last
);
	localparam int AW = $clog2(PAGE_BYTES);

	// Step index within a job; data bytes of a page occupy steps 4 onward.
	logic [6:0] step_q;
	logic       busy_q;
	logic       fetch_q;
	logic [7:0] byte_c;
	logic       last_c, ov_q, adv;
	logic [6:0] dstep;

	assign dstep = step_q - 7'd4;
	assign ram_raddr = dstep[AW-1:0];
	assign adv = busy_q && !fetch_q && (!ov_q || !out_stall);

	always_comb begin
		byte_c = 8'h00;
		last_c = 1'b1;
		unique case (job.kind)
			stk_pkg::JOB_SYNC: begin
				byte_c = (step_q == 7'd0) ? stk_pkg::CMD_SYNC : stk_pkg::CRC_EOP;
				last_c = (step_q == 7'd1);
			end
			stk_pkg::JOB_ENTER: begin
				byte_c = (step_q == 7'd0) ? stk_pkg::CMD_ENTER : stk_pkg::CRC_EOP;
				last_c = (step_q == 7'd1);
			end
			stk_pkg::JOB_LEAVE: begin
				byte_c = (step_q == 7'd0) ? stk_pkg::CMD_LEAVE : stk_pkg::CRC_EOP;
				last_c = (step_q == 7'd1);
			end
			stk_pkg::JOB_ADDR: begin
				case (step_q[1:0])
					2'd0: byte_c = stk_pkg::CMD_ADDR;
					2'd1: byte_c = job.addr[7:0];
					2'd2: byte_c = job.addr[15:8];
					default: byte_c = stk_pkg::CRC_EOP;
				endcase
				last_c = (step_q == 7'd3);
			end
			stk_pkg::JOB_PROG: begin
				last_c = 1'b0;
				if (step_q == 7'd0) begin
					byte_c = stk_pkg::CMD_PROG;
				end else if (step_q == 7'd1) begin
					byte_c = 8'h00;
				end else if (step_q == 7'd2) begin
					byte_c = {2'b00, job.fill};
				end else if (step_q == 7'd3) begin
					byte_c = stk_pkg::MEM_FLASH;
				end else if (dstep < {1'b0, job.fill}) begin
					byte_c = ram_rdata;
				end else begin
					byte_c = stk_pkg::CRC_EOP;
					last_c = 1'b1;
				end
			end
			default: begin
				byte_c = 8'h00;
				last_c = 1'b1;
			end
		endcase
	end

	assign job_pop = adv && last_c;
	assign out_valid = ov_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			busy_q <= 1'b0;
			fetch_q <= 1'b0;
			ov_q <= 1'b0;
		end else begin
			if (ov_q && !out_stall) begin
				ov_q <= 1'b0;
			end
			if (!busy_q) begin
				if (job_valid) begin
					busy_q <= 1'b1;
					step_q <= '0;
				end
			end else if (fetch_q) begin
				fetch_q <= 1'b0;
			end else if (adv) begin
				ov_q <= 1'b1;
				if (last_c) begin
					busy_q <= 1'b0;
					step_q <= '0;
				end else begin
					step_q <= step_q + 7'd1;
					fetch_q <= (job.kind == stk_pkg::JOB_PROG) && (step_q >= 7'd3);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tx_valid <= (job.kind != stk_pkg::JOB_NONE);
			tx_byte <= byte_c;
			status <= job.status;
			last <= last_c;
		end
	end
endmodule
`default_nettype wire

// ===== design/stk_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// STK500 port checker
// Port-level properties of the page programmer.
// ----------------------------------------------------------------------------
module stk_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       out_valid,
	input wire logic       out_stall,
	input wire logic       tx_valid,
	input wire logic [7:0] tx_byte,
	input wire logic       last
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(tx_byte))
		else $error("stalled result changed");
	a_idle_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !tx_valid |-> last)
		else $error("empty result not last");
	a_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !tx_valid |-> tx_byte == 8'h00)
		else $error("empty result with nonzero byte");
endmodule

bind stk500_page_programmer stk_checker u_checker (
	.clk(clk), .arst_n(arst_n), .out_valid(out_valid), .out_stall(out_stall),
	.tx_valid(tx_valid), .tx_byte(tx_byte), .last(last)
);
`default_nettype wire
